// ----- sv/scc_pkg.sv -----
// scc_pkg: shared types and constants for the strongly connected components block
// no dependencies; used by strongly_connected_components
package scc_pkg;

    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_RUN = 1'b1;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic                mode;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
    } item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_id;
        logic                component_end;
        logic                last;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_APP1,
        ST_APP2,
        ST_P1_SCAN,
        ST_HEAD,
        ST_TOP,
        ST_EDGE,
        ST_POP,
        ST_BLD_VRD,
        ST_BLD_VWAIT,
        ST_BLD_P,
        ST_BLD_E,
        ST_P2_SCAN,
        ST_P2_WAIT,
        ST_FLUSH
    } state_t;

endpackage

// ----- sv/scc_ram.sv -----
// scc_ram: generic single-write, single-read memory with registered read data
// no dependencies
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/strongly_connected_components.sv -----
// strongly_connected_components: kosaraju component search over a loaded edge list
// depends on scc_pkg and scc_ram
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_ready   scc_pkg::item_t (mode, from, to)
//  result    out        result_valid/result_ready scc_pkg::result_t (vertex, end, last)
//  cfg       in         cfg_we (no wait)          cfg_data = vertex_count
//
// an edge transaction reads the head/tail entry, appends the new slot and, if the list
// was not empty, writes the old tail's link; a dropped edge is taken and left in idle
// a run walks the forward lists (first pass), builds the transposed lists and walks them
// in reverse finish order (second pass), then flushes the last result;
// every step waits on the registered read data of the list memories
// one item is in work at a time; item_ready is high only while idle
// result stalls hold the second pass; reset clears lists, counters and marks at once
module strongly_connected_components #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [scc_pkg::COUNT_W-1:0]       cfg_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  scc_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output scc_pkg::result_t                  result
);

    // widths derived from capacities
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SPW = $clog2(MAX_VERTICES + 1);
    localparam int CW  = scc_pkg::COUNT_W;
    localparam logic [LW-1:0]  NULL_LINK = LW'(MAX_EDGES);
    localparam logic [CW-1:0]  MV_C      = CW'(MAX_VERTICES);
    localparam logic [SPW-1:0] MV_SP     = SPW'(MAX_VERTICES);

    scc_pkg::state_t state_reg, state_next;

    logic [CW-1:0]           vcount_reg;
    logic [LW-1:0]           edge_total_reg, edge_total_next;
    logic [MAX_VERTICES-1:0] fwd_hv_reg, fwd_hv_next;
    logic [MAX_VERTICES-1:0] rev_hv_reg, rev_hv_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [VW-1:0]           src_reg, src_next;
    logic [VW-1:0]           dst_reg, dst_next;
    logic [LW-1:0]           idx_reg, idx_next;
    logic                    app_rev_reg, app_rev_next;
    logic [SPW-1:0]          sp_reg, sp_next;
    logic [VW-1:0]           top_v_reg, top_v_next;
    logic [LW-1:0]           top_next_reg, top_next_next;
    logic [VW-1:0]           t_reg, t_next;
    logic                    second_reg, second_next;
    logic [CW-1:0]           scan_reg, scan_next;
    logic [SPW-1:0]          fc_reg, fc_next;
    logic [SPW-1:0]          i_reg, i_next;
    logic [LW-1:0]           p_reg, p_next;
    logic [LW-1:0]           r_reg, r_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [VW-1:0]           pend_v_reg, pend_v_next;
    logic                    pend_ce_reg, pend_ce_next;
    logic                    out_valid_reg, out_valid_next;
    scc_pkg::result_t        out_reg, out_next;

    // memory ports
    logic               ht_re;
    logic [VW-1:0]      ht_ra;
    logic [2*LW-1:0]    fht_rd, rht_rd;
    logic               fht_we, rht_we;
    logic [VW-1:0]      ht_wa;
    logic [2*LW-1:0]    ht_wd;
    logic               edge_re;
    logic [AW-1:0]      edge_ra;
    logic [VW-1:0]      ftg_rd, rtg_rd;
    logic [LW-1:0]      flk_rd, rlk_rd;
    logic               ftg_we, rtg_we;
    logic [AW-1:0]      tg_wa;
    logic               flk_we, rlk_we;
    logic [AW-1:0]      lk_wa;
    logic [LW-1:0]      lk_wd;
    logic               fin_we, fin_re;
    logic [VW-1:0]      fin_wa, fin_ra, fin_rd;
    logic               stk_we, stk_re;
    logic [VW-1:0]      stk_wa, stk_ra;
    logic [VW+LW-1:0]   stk_wd, stk_rd;

    // derived values
    logic [CW-1:0]      n;
    logic               out_free;
    logic               item_acc;
    logic [2*LW-1:0]    ht_sel;
    logic               hv_sel;
    logic [VW-1:0]      tg_sel;
    logic [LW-1:0]      lk_sel;
    logic               app_hv;
    logic               add_ok;
    logic               push_ok;
    logic [SPW-1:0]     sp_m1, sp_m2, i_m1;
    logic               fin_ok;

    assign n        = (vcount_reg > MV_C) ? MV_C : vcount_reg;
    assign out_free = !out_valid_reg || result_ready;
    assign item_acc = item_valid && item_ready;
    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);
    assign i_m1     = i_reg - SPW'(1);

    // list selection: appends follow their own list, walks follow the pass
    assign ht_sel = (((state_reg == scc_pkg::ST_APP1) || (state_reg == scc_pkg::ST_APP2))
                     ? app_rev_reg : second_reg) ? rht_rd : fht_rd;
    assign hv_sel = second_reg ? rev_hv_reg[t_reg] : fwd_hv_reg[t_reg];
    assign tg_sel = second_reg ? rtg_rd : ftg_rd;
    assign lk_sel = second_reg ? rlk_rd : flk_rd;
    assign app_hv = app_rev_reg ? rev_hv_reg[src_reg] : fwd_hv_reg[src_reg];

    assign add_ok = (CW'(item.from_vertex) < n) && (CW'(item.to_vertex) < n)
                    && (edge_total_reg < LW'(MAX_EDGES));
    assign push_ok = (CW'(tg_sel) < n) && !visited_reg[tg_sel] && (sp_reg < MV_SP);
    assign fin_ok  = (CW'(fin_rd) < n) && !visited_reg[fin_rd];

    assign item_ready   = (state_reg == scc_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.mode == scc_pkg::MODE_RUN)
                    begin
                        state_next = scc_pkg::ST_P1_SCAN;
                    end
                    else if (add_ok)
                    begin
                        state_next = scc_pkg::ST_APP1;
                    end
                end
            end
            scc_pkg::ST_APP1:
            begin
                if (app_hv)
                begin
                    state_next = scc_pkg::ST_APP2;
                end
                else
                begin
                    state_next = app_rev_reg ? scc_pkg::ST_BLD_P : scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_APP2:
            begin
                state_next = app_rev_reg ? scc_pkg::ST_BLD_P : scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_P1_SCAN:
            begin
                if (scan_reg == n)
                begin
                    state_next = scc_pkg::ST_BLD_VRD;
                end
                else if (!visited_reg[scan_reg[VW-1:0]])
                begin
                    state_next = scc_pkg::ST_HEAD;
                end
            end
            scc_pkg::ST_HEAD:
            begin
                if (!second_reg || out_free)
                begin
                    state_next = scc_pkg::ST_TOP;
                end
            end
            scc_pkg::ST_TOP:
            begin
                if (top_next_reg == NULL_LINK)
                begin
                    if (sp_reg == SPW'(1))
                    begin
                        state_next = second_reg ? scc_pkg::ST_P2_SCAN : scc_pkg::ST_P1_SCAN;
                    end
                    else
                    begin
                        state_next = scc_pkg::ST_POP;
                    end
                end
                else
                begin
                    state_next = scc_pkg::ST_EDGE;
                end
            end
            scc_pkg::ST_EDGE:
            begin
                state_next = push_ok ? scc_pkg::ST_HEAD : scc_pkg::ST_TOP;
            end
            scc_pkg::ST_POP:
            begin
                state_next = scc_pkg::ST_TOP;
            end
            scc_pkg::ST_BLD_VRD:
            begin
                state_next = (scan_reg == n) ? scc_pkg::ST_P2_SCAN : scc_pkg::ST_BLD_VWAIT;
            end
            scc_pkg::ST_BLD_VWAIT:
            begin
                state_next = scc_pkg::ST_BLD_P;
            end
            scc_pkg::ST_BLD_P:
            begin
                state_next = (p_reg == NULL_LINK) ? scc_pkg::ST_BLD_VRD : scc_pkg::ST_BLD_E;
            end
            scc_pkg::ST_BLD_E:
            begin
                if ((CW'(ftg_rd) < n) && (r_reg < LW'(MAX_EDGES)))
                begin
                    state_next = scc_pkg::ST_APP1;
                end
                else
                begin
                    state_next = scc_pkg::ST_BLD_P;
                end
            end
            scc_pkg::ST_P2_SCAN:
            begin
                if (i_reg == '0)
                begin
                    state_next = pend_valid_reg ? scc_pkg::ST_FLUSH : scc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = scc_pkg::ST_P2_WAIT;
                end
            end
            scc_pkg::ST_P2_WAIT:
            begin
                state_next = fin_ok ? scc_pkg::ST_HEAD : scc_pkg::ST_P2_SCAN;
            end
            scc_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_IDLE;
            end
        endcase
    end

    // memory ports and register updates
    always_comb
    begin
        ht_re   = 1'b0;
        ht_ra   = scan_reg[VW-1:0];
        fht_we  = 1'b0;
        rht_we  = 1'b0;
        ht_wa   = src_reg;
        ht_wd   = {app_hv ? ht_sel[2*LW-1:LW] : idx_reg, idx_reg};
        edge_re = 1'b0;
        edge_ra = top_next_reg[AW-1:0];
        ftg_we  = 1'b0;
        rtg_we  = 1'b0;
        tg_wa   = idx_reg[AW-1:0];
        flk_we  = 1'b0;
        rlk_we  = 1'b0;
        lk_wa   = idx_reg[AW-1:0];
        lk_wd   = NULL_LINK;
        fin_we  = 1'b0;
        fin_wa  = fc_reg[VW-1:0];
        fin_re  = 1'b0;
        fin_ra  = i_m1[VW-1:0];
        stk_we  = 1'b0;
        stk_wa  = sp_m1[VW-1:0];
        stk_wd  = {top_v_reg, lk_sel};
        stk_re  = 1'b0;
        stk_ra  = sp_m2[VW-1:0];

        edge_total_next = edge_total_reg;
        fwd_hv_next     = fwd_hv_reg;
        rev_hv_next     = rev_hv_reg;
        visited_next    = visited_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        idx_next        = idx_reg;
        app_rev_next    = app_rev_reg;
        sp_next         = sp_reg;
        top_v_next      = top_v_reg;
        top_next_next   = top_next_reg;
        t_next          = t_reg;
        second_next     = second_reg;
        scan_next       = scan_reg;
        fc_next         = fc_reg;
        i_next          = i_reg;
        p_next          = p_reg;
        r_next          = r_reg;
        pend_valid_next = pend_valid_reg;
        pend_v_next     = pend_v_reg;
        pend_ce_next    = pend_ce_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_next        = out_reg;

        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                ht_ra = item.from_vertex[VW-1:0];
                if (item_acc)
                begin
                    if (item.mode == scc_pkg::MODE_RUN)
                    begin
                        visited_next    = '0;
                        fc_next         = '0;
                        scan_next       = '0;
                        second_next     = 1'b0;
                        pend_valid_next = 1'b0;
                        pend_ce_next    = 1'b0;
                    end
                    else if (add_ok)
                    begin
                        ht_re        = 1'b1;
                        src_next     = item.from_vertex[VW-1:0];
                        dst_next     = item.to_vertex[VW-1:0];
                        idx_next     = edge_total_reg;
                        app_rev_next = 1'b0;
                    end
                end
            end
            scc_pkg::ST_APP1:
            begin
                // new slot gets a null link, list head/tail updated
                if (app_rev_reg)
                begin
                    rtg_we            = 1'b1;
                    rlk_we            = 1'b1;
                    rht_we            = 1'b1;
                    rev_hv_next[src_reg] = 1'b1;
                    r_next            = r_reg + LW'(1);
                end
                else
                begin
                    ftg_we            = 1'b1;
                    flk_we            = 1'b1;
                    fht_we            = 1'b1;
                    fwd_hv_next[src_reg] = 1'b1;
                    edge_total_next   = edge_total_reg + LW'(1);
                end
            end
            scc_pkg::ST_APP2:
            begin
                // link old tail to the new slot
                lk_wa  = ht_sel[AW-1:0];
                lk_wd  = idx_reg;
                flk_we = !app_rev_reg;
                rlk_we = app_rev_reg;
            end
            scc_pkg::ST_P1_SCAN:
            begin
                if (scan_reg != n)
                begin
                    if (visited_reg[scan_reg[VW-1:0]])
                    begin
                        scan_next = scan_reg + CW'(1);
                    end
                    else
                    begin
                        ht_re = 1'b1;
                        visited_next[scan_reg[VW-1:0]] = 1'b1;
                        t_next  = scan_reg[VW-1:0];
                        sp_next = '0;
                    end
                end
                else
                begin
                    rev_hv_next = '0;
                    scan_next   = '0;
                    r_next      = '0;
                end
            end
            scc_pkg::ST_HEAD:
            begin
                if (!second_reg || out_free)
                begin
                    top_v_next    = t_reg;
                    top_next_next = hv_sel ? ht_sel[2*LW-1:LW] : NULL_LINK;
                    sp_next       = sp_reg + SPW'(1);
                    if (second_reg)
                    begin
                        // previous pending vertex goes out, this one waits for its marks
                        if (pend_valid_reg)
                        begin
                            out_valid_next          = 1'b1;
                            out_next.vertex_id      = scc_pkg::VERTEX_W'(pend_v_reg);
                            out_next.component_end  = pend_ce_reg;
                            out_next.last           = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_v_next     = t_reg;
                        pend_ce_next    = 1'b0;
                    end
                end
            end
            scc_pkg::ST_TOP:
            begin
                if (top_next_reg == NULL_LINK)
                begin
                    if (!second_reg && (fc_reg < MV_SP))
                    begin
                        fin_we  = 1'b1;
                        fc_next = fc_reg + SPW'(1);
                    end
                    sp_next = sp_m1;
                    if (sp_reg == SPW'(1))
                    begin
                        if (second_reg)
                        begin
                            pend_ce_next = 1'b1;
                        end
                        else
                        begin
                            scan_next = scan_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        stk_re = 1'b1;
                    end
                end
                else
                begin
                    edge_re = 1'b1;
                end
            end
            scc_pkg::ST_EDGE:
            begin
                top_next_next = lk_sel;
                if (push_ok)
                begin
                    visited_next[tg_sel] = 1'b1;
                    stk_we = 1'b1;
                    t_next = tg_sel;
                    ht_re  = 1'b1;
                    ht_ra  = tg_sel;
                end
            end
            scc_pkg::ST_POP:
            begin
                top_v_next    = stk_rd[VW+LW-1:LW];
                top_next_next = stk_rd[LW-1:0];
            end
            scc_pkg::ST_BLD_VRD:
            begin
                if (scan_reg == n)
                begin
                    visited_next = '0;
                    i_next       = fc_reg;
                    second_next  = 1'b1;
                end
                else
                begin
                    ht_re = 1'b1;
                end
            end
            scc_pkg::ST_BLD_VWAIT:
            begin
                p_next = fwd_hv_reg[scan_reg[VW-1:0]] ? fht_rd[2*LW-1:LW] : NULL_LINK;
            end
            scc_pkg::ST_BLD_P:
            begin
                edge_ra = p_reg[AW-1:0];
                if (p_reg == NULL_LINK)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                else
                begin
                    edge_re = 1'b1;
                end
            end
            scc_pkg::ST_BLD_E:
            begin
                p_next = flk_rd;
                ht_ra  = ftg_rd;
                if ((CW'(ftg_rd) < n) && (r_reg < LW'(MAX_EDGES)))
                begin
                    ht_re        = 1'b1;
                    src_next     = ftg_rd;
                    dst_next     = scan_reg[VW-1:0];
                    idx_next     = r_reg;
                    app_rev_next = 1'b1;
                end
            end
            scc_pkg::ST_P2_SCAN:
            begin
                if (i_reg != '0)
                begin
                    fin_re = 1'b1;
                end
            end
            scc_pkg::ST_P2_WAIT:
            begin
                i_next = i_m1;
                ht_ra  = fin_rd;
                if (fin_ok)
                begin
                    visited_next[fin_rd] = 1'b1;
                    t_next  = fin_rd;
                    sp_next = '0;
                    ht_re   = 1'b1;
                end
            end
            scc_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.vertex_id     = scc_pkg::VERTEX_W'(pend_v_reg);
                    out_next.component_end = 1'b1;
                    out_next.last          = 1'b1;
                    pend_valid_next        = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= scc_pkg::ST_IDLE;
            vcount_reg      <= scc_pkg::VERTEX_COUNT_RESET;
            edge_total_reg  <= '0;
            fwd_hv_reg      <= '0;
            rev_hv_reg      <= '0;
            visited_reg     <= '0;
            sp_reg          <= '0;
            second_reg      <= 1'b0;
            scan_reg        <= '0;
            fc_reg          <= '0;
            i_reg           <= '0;
            r_reg           <= '0;
            app_rev_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_ce_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                vcount_reg  <= cfg_data;
            end
            edge_total_reg  <= edge_total_next;
            fwd_hv_reg      <= fwd_hv_next;
            rev_hv_reg      <= rev_hv_next;
            visited_reg     <= visited_next;
            sp_reg          <= sp_next;
            second_reg      <= second_next;
            scan_reg        <= scan_next;
            fc_reg          <= fc_next;
            i_reg           <= i_next;
            r_reg           <= r_next;
            app_rev_reg     <= app_rev_next;
            pend_valid_reg  <= pend_valid_next;
            pend_ce_reg     <= pend_ce_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        idx_reg      <= idx_next;
        top_v_reg    <= top_v_next;
        top_next_reg <= top_next_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        pend_v_reg   <= pend_v_next;
        out_reg      <= out_next;
    end

    // forward lists: head/tail per vertex, target and link per edge slot
    scc_ram #(.WIDTH(2*LW), .DEPTH(MAX_VERTICES)) u_fwd_ht (
        .clk(clk), .we(fht_we), .waddr(ht_wa), .wdata(ht_wd),
        .re(ht_re), .raddr(ht_ra), .rdata(fht_rd)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_fwd_tgt (
        .clk(clk), .we(ftg_we), .waddr(tg_wa), .wdata(dst_reg),
        .re(edge_re), .raddr(edge_ra), .rdata(ftg_rd)
    );

    scc_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_fwd_lnk (
        .clk(clk), .we(flk_we), .waddr(lk_wa), .wdata(lk_wd),
        .re(edge_re), .raddr(edge_ra), .rdata(flk_rd)
    );

    // transposed lists, rebuilt on every run
    scc_ram #(.WIDTH(2*LW), .DEPTH(MAX_VERTICES)) u_rev_ht (
        .clk(clk), .we(rht_we), .waddr(ht_wa), .wdata(ht_wd),
        .re(ht_re), .raddr(ht_ra), .rdata(rht_rd)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_rev_tgt (
        .clk(clk), .we(rtg_we), .waddr(tg_wa), .wdata(dst_reg),
        .re(edge_re), .raddr(edge_ra), .rdata(rtg_rd)
    );

    scc_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_rev_lnk (
        .clk(clk), .we(rlk_we), .waddr(lk_wa), .wdata(lk_wd),
        .re(edge_re), .raddr(edge_ra), .rdata(rlk_rd)
    );

    // finish order of the first pass
    scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
        .clk(clk), .we(fin_we), .waddr(fin_wa), .wdata(top_v_reg),
        .re(fin_re), .raddr(fin_ra), .rdata(fin_rd)
    );

    // walk stack below the top entry, top lives in registers
    scc_ram #(.WIDTH(VW+LW), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
    );

endmodule
